>>> sv/htfd_pkg.sv
// Shared types, constants and the CRC-8 helper for the humidity/temperature frame decoder.
package htfd_pkg;

    // Channel widths.
    localparam int BYTE_W     = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 4;

    // Result field widths.
    localparam int WORD_W     = 16;
    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int SERIAL_W   = 32;
    localparam int STATUS_W   = 2;

    // CRC-8 with polynomial 0x31, seeded with 0xFF, MSB first.
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CRC  = 2'd1,
        STATUS_XFER = 2'd2
    } status_t;

    // Position of the next byte inside the six-byte frame.
    typedef enum logic [2:0] {
        POS_W0_HI  = 3'd0,
        POS_W0_LO  = 3'd1,
        POS_W0_CRC = 3'd2,
        POS_W1_HI  = 3'd3,
        POS_W1_LO  = 3'd4,
        POS_W1_CRC = 3'd5
    } byte_pos_t;

    // Runs one byte through the CRC-8, one bit per step.
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/htfd_scale.sv
// Scales the raw temperature and humidity words to centi-units.
module htfd_scale (
    input  logic [htfd_pkg::WORD_W-1:0]        temp_word,
    input  logic [htfd_pkg::WORD_W-1:0]        hum_word,
    output logic signed [htfd_pkg::TEMP_W-1:0] temperature,
    output logic [htfd_pkg::HUM_W-1:0]         humidity
);
    import htfd_pkg::*;

    localparam int PROD_W = 31;
    localparam int QUOT_W = 15;
    localparam int SUM_W  = 16;

    localparam logic [PROD_W-1:0]       TEMP_SCALE  = 31'd17500;
    localparam logic [PROD_W-1:0]       HUM_SCALE   = 31'd12500;
    localparam logic [QUOT_W+1:0]       FULL_SCALE  = 17'd65535;
    localparam logic signed [SUM_W-1:0] TEMP_OFFSET = -16'sd4500;
    localparam logic signed [SUM_W-1:0] HUM_OFFSET  = -16'sd600;
    localparam logic signed [SUM_W-1:0] HUM_MAX     = 16'sd10000;

    // Floor division by 65535: x = q*65536 + lo = q*65535 + (q + lo),
    // and q + lo stays below twice the divisor, so one correction is enough.
    function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [QUOT_W-1:0] q0;
        logic [QUOT_W+1:0] rem;
        q0  = x[PROD_W-1:WORD_W];
        rem = {1'b0, x[WORD_W-1:0]} + {2'b00, q0};
        return (rem >= FULL_SCALE) ? q0 + QUOT_W'(1) : q0;
    endfunction

    logic [PROD_W-1:0]       temp_prod;
    logic [PROD_W-1:0]       hum_prod;
    logic [QUOT_W-1:0]       temp_quot;
    logic [QUOT_W-1:0]       hum_quot;
    logic signed [SUM_W-1:0] temp_sum;
    logic signed [SUM_W-1:0] hum_sum;

    // Products by the scale constants, then the reciprocal division.
    assign temp_prod = {{(PROD_W-WORD_W){1'b0}}, temp_word} * TEMP_SCALE;
    assign hum_prod  = {{(PROD_W-WORD_W){1'b0}}, hum_word} * HUM_SCALE;
    assign temp_quot = div_full_scale(temp_prod);
    assign hum_quot  = div_full_scale(hum_prod);

    // Offsets; the temperature always fits, the humidity is clamped.
    assign temp_sum    = $signed({1'b0, temp_quot}) + TEMP_OFFSET;
    assign hum_sum     = $signed({1'b0, hum_quot}) + HUM_OFFSET;
    assign temperature = temp_sum[TEMP_W-1:0];

    always_comb
    begin
        priority if (hum_sum < 0) begin
            humidity = '0;
        end
        else if (hum_sum > HUM_MAX) begin
            humidity = HUM_MAX[HUM_W-1:0];
        end
        else begin
            humidity = hum_sum[HUM_W-1:0];
        end
    end

endmodule

>>> sv/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature sensor frame decoder.
// The block takes one frame byte per transfer and sustains one byte per clock cycle while no
// result waiting at the output stalls it: each byte is registered at the input, passes once
// through the CRC, word assembly and scaling logic, and its result, if any, is loaded into the
// output register when the byte leaves the input register.
// A result waiting at the output stalls only a registered byte that would give another result.
// Only the sixth byte of a frame and a byte marked as a failed transfer give a result; bytes
// zero to four only update the frame state. frame_start restarts the frame at the byte it
// marks. cfg_wdata selects measurement (0) or serial-number (1) decoding and must be written
// only while the block is idle, which it does not enforce. There is no clearing pass after reset.
module humidity_temp_frame_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] data_byte
    input  logic [htfd_pkg::BYTE_W-1:0]     s_axis_tdata,
    // [0] frame_start, [1] transfer_failed
    input  logic [htfd_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [14:0] temperature, [28:15] humidity, [60:29] serial,
    // [63:61] zero
    output logic [htfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status, [2] reading ok, [3] from_hold
    output logic [htfd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import htfd_pkg::*;

    // Configuration.
    logic frame_kind_reg;

    // Input register.
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;
    logic              in_failed_reg;

    // Frame state.
    byte_pos_t         pos_reg, pos_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [WORD_W-1:0] first_word_reg, first_word_next;
    logic              first_word_ok_reg, first_word_ok_next;
    logic [WORD_W-1:0] second_word_reg, second_word_next;

    // Held reading.
    logic signed [TEMP_W-1:0] held_temp_reg, held_temp_next;
    logic [HUM_W-1:0]         held_hum_reg, held_hum_next;
    logic                     held_valid_reg, held_valid_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [HUM_W-1:0]         out_hum_reg;
    logic [SERIAL_W-1:0]      out_serial_reg;
    status_t                  out_status_reg;
    logic                     out_rvalid_reg;
    logic                     out_hold_reg;

    // Datapath signals.
    logic                     s_accept;
    logic                     produce;
    logic                     advance;
    logic                     restart;
    byte_pos_t                pos_eff;
    logic [BYTE_W-1:0]        crc_eff;
    logic                     frame_ok;
    logic signed [TEMP_W-1:0] scaled_temp;
    logic [HUM_W-1:0]         scaled_hum;
    logic signed [TEMP_W-1:0] res_temp;
    logic [HUM_W-1:0]         res_hum;
    logic [SERIAL_W-1:0]      res_serial;
    status_t                  res_status;
    logic                     res_rvalid;
    logic                     res_hold;

    // Conversion of the assembled words.
    htfd_scale u_scale (
        .temp_word   (first_word_reg),
        .hum_word    (second_word_reg),
        .temperature (scaled_temp),
        .humidity    (scaled_hum)
    );

    // Handshake: the registered byte moves on when its result has room.
    assign produce       = in_failed_reg || (pos_eff == POS_W1_CRC);
    assign advance       = in_valid_reg && (!produce || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end
        else if (advance) begin
            in_valid_next = 1'b0;
        end
        else begin
            in_valid_next = in_valid_reg;
        end
    end

    // A frame start or an out-of-range position restarts the frame.
    assign restart  = in_start_reg || (pos_reg > POS_W1_CRC);
    assign pos_eff  = restart ? POS_W0_HI : pos_reg;
    assign crc_eff  = restart ? CRC_INIT : crc_reg;
    assign frame_ok = first_word_ok_reg && (crc_eff == in_byte_reg);

    // Next byte position.
    always_comb
    begin
        pos_next = pos_reg;
        if (advance) begin
            if (in_failed_reg) begin
                pos_next = POS_W0_HI;
            end
            else begin
                unique case (pos_eff)
                    POS_W0_HI:  pos_next = POS_W0_LO;
                    POS_W0_LO:  pos_next = POS_W0_CRC;
                    POS_W0_CRC: pos_next = POS_W1_HI;
                    POS_W1_HI:  pos_next = POS_W1_LO;
                    POS_W1_LO:  pos_next = POS_W1_CRC;
                    POS_W1_CRC: pos_next = POS_W0_HI;
                    default:    pos_next = POS_W0_HI;
                endcase
            end
        end
    end

    // CRC and word assembly.
    always_comb
    begin
        crc_next           = crc_reg;
        first_word_next    = first_word_reg;
        first_word_ok_next = first_word_ok_reg;
        second_word_next   = second_word_reg;
        if (advance) begin
            if (in_failed_reg) begin
                crc_next = CRC_INIT;
            end
            else begin
                unique case (pos_eff)
                    POS_W0_HI:
                    begin
                        crc_next        = crc8_update(CRC_INIT, in_byte_reg);
                        first_word_next = {in_byte_reg, first_word_reg[BYTE_W-1:0]};
                    end
                    POS_W0_LO:
                    begin
                        crc_next        = crc8_update(crc_eff, in_byte_reg);
                        first_word_next = {first_word_reg[WORD_W-1:BYTE_W], in_byte_reg};
                    end
                    POS_W0_CRC:
                    begin
                        first_word_ok_next = (crc_eff == in_byte_reg);
                        crc_next           = CRC_INIT;
                    end
                    POS_W1_HI:
                    begin
                        crc_next         = crc8_update(crc_eff, in_byte_reg);
                        second_word_next = {in_byte_reg, second_word_reg[BYTE_W-1:0]};
                    end
                    POS_W1_LO:
                    begin
                        crc_next         = crc8_update(crc_eff, in_byte_reg);
                        second_word_next = {second_word_reg[WORD_W-1:BYTE_W], in_byte_reg};
                    end
                    default:
                    begin
                        crc_next = CRC_INIT;
                    end
                endcase
            end
        end
    end

    // Result selection and update of the held reading.
    always_comb
    begin
        held_temp_next  = held_temp_reg;
        held_hum_next   = held_hum_reg;
        held_valid_next = held_valid_reg;
        res_serial      = '0;
        res_status      = STATUS_XFER;
        res_temp        = held_valid_reg ? held_temp_reg : '0;
        res_hum         = held_valid_reg ? held_hum_reg : '0;
        res_rvalid      = held_valid_reg;
        res_hold        = held_valid_reg;
        priority if (in_failed_reg) begin
            res_status = STATUS_XFER;
        end
        else if (!frame_ok) begin
            res_status = STATUS_CRC;
        end
        else if (frame_kind_reg) begin
            res_status = STATUS_OK;
            res_serial = {first_word_reg, second_word_reg};
            res_temp   = '0;
            res_hum    = '0;
            res_rvalid = 1'b0;
            res_hold   = 1'b0;
        end
        else begin
            res_status = STATUS_OK;
            res_temp   = scaled_temp;
            res_hum    = scaled_hum;
            res_rvalid = 1'b1;
            res_hold   = 1'b0;
            // Only the closing byte of a good frame updates the held reading.
            if (advance && produce) begin
                held_temp_next  = scaled_temp;
                held_hum_next   = scaled_hum;
                held_valid_next = 1'b1;
            end
        end
    end

    // Output valid: set by a new result, cleared by its transfer.
    always_comb
    begin
        if (advance && produce) begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_kind_reg    <= 1'b0;
            in_valid_reg      <= 1'b0;
            pos_reg           <= POS_W0_HI;
            crc_reg           <= CRC_INIT;
            first_word_reg    <= '0;
            first_word_ok_reg <= 1'b0;
            second_word_reg   <= '0;
            held_temp_reg     <= '0;
            held_hum_reg      <= '0;
            held_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                frame_kind_reg <= cfg_wdata;
            end
            in_valid_reg      <= in_valid_next;
            pos_reg           <= pos_next;
            crc_reg           <= crc_next;
            first_word_reg    <= first_word_next;
            first_word_ok_reg <= first_word_ok_next;
            second_word_reg   <= second_word_next;
            held_temp_reg     <= held_temp_next;
            held_hum_reg      <= held_hum_next;
            held_valid_reg    <= held_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            in_byte_reg   <= s_axis_tdata;
            in_start_reg  <= s_axis_tuser[0];
            in_failed_reg <= s_axis_tuser[1];
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (advance && produce) begin
            out_temp_reg   <= res_temp;
            out_hum_reg    <= res_hum;
            out_serial_reg <= res_serial;
            out_status_reg <= res_status;
            out_rvalid_reg <= res_rvalid;
            out_hold_reg   <= res_hold;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-TEMP_W-HUM_W-SERIAL_W){1'b0}},
                            out_serial_reg, out_hum_reg, out_temp_reg};
    assign m_axis_tuser  = {out_hold_reg, out_rvalid_reg, out_status_reg};

`ifndef SYNTHESIS
    // Once a good measurement is held, it stays available.
    a_held_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |=> held_valid_reg)
        else $error("held reading was lost");

    // A repeated reading only comes with an error status and a valid reading.
    a_hold_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hold_reg) |->
        (out_rvalid_reg && (out_status_reg != STATUS_OK)))
        else $error("held reading reported without an error");

    // A failed transfer leaving the input register gives a transfer-failed result.
    a_xfer_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_failed_reg) |=>
        (out_valid_reg && (out_status_reg == STATUS_XFER)))
        else $error("failed transfer did not give a transfer-failed result");
`endif

endmodule

>>> tb/humidity_temp_frame_decoder_tb.sv
// Self-checking testbench for the humidity/temperature frame decoder.
module humidity_temp_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import htfd_pkg::*;

    localparam int RUN_LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;

    // One decoded reading as it leaves the block.
    typedef struct packed {
        logic [TEMP_W-1:0]   temp;
        logic [HUM_W-1:0]    hum;
        logic [SERIAL_W-1:0] serial;
        status_t             status;
        logic                valid;
        logic                hold;
    } reading_t;

    // Tracks the frame state of the block and checks every reading it emits.
    class frame_scoreboard;
        bit                frame_kind;
        byte_pos_t         pos;
        bit [BYTE_W-1:0]   crc;
        bit [WORD_W-1:0]   word0;
        bit [WORD_W-1:0]   word1;
        bit                word0_ok;
        bit [TEMP_W-1:0]   held_temp;
        bit [HUM_W-1:0]    held_hum;
        bit                held_ok;
        reading_t          expected_readings[$];
        int                errors;

        function new();
            frame_kind = 1'b0;
            pos        = POS_W0_HI;
            crc        = 8'hFF;
            word0      = '0;
            word1      = '0;
            word0_ok   = 1'b0;
            held_temp  = '0;
            held_hum   = '0;
            held_ok    = 1'b0;
            errors     = 0;
        endfunction

        // CRC-8, polynomial 0x31, shifted MSB first.
        static function bit [7:0] crc_step(bit [7:0] acc, bit [7:0] b);
            bit [7:0] r;
            r = acc ^ b;
            repeat (8) begin
                r = r[7] ? ((r << 1) ^ 8'h31) : (r << 1);
            end
            return r;
        endfunction

        function void set_frame_kind(bit k);
            frame_kind = k;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Error readings repeat the last good measurement when there is one.
        function void push_error(status_t st);
            reading_t r;
            r = '0;
            r.status = st;
            if (held_ok) begin
                r.temp  = held_temp;
                r.hum   = held_hum;
                r.valid = 1'b1;
                r.hold  = 1'b1;
            end
            expected_readings.push_back(r);
        endfunction

        // Advances the frame state by one accepted byte transfer.
        function void take_byte(bit [7:0] b, bit start, bit failed);
            reading_t r;
            int       t_val;
            int       h_val;
            if (failed) begin
                pos = POS_W0_HI;
                crc = 8'hFF;
                push_error(STATUS_XFER);
                return;
            end
            if (start) begin
                pos = POS_W0_HI;
                crc = 8'hFF;
            end
            case (pos)
                POS_W0_HI:
                begin
                    crc   = crc_step(8'hFF, b);
                    word0 = {b, 8'h00};
                    pos   = POS_W0_LO;
                end
                POS_W0_LO:
                begin
                    crc        = crc_step(crc, b);
                    word0[7:0] = b;
                    pos        = POS_W0_CRC;
                end
                POS_W0_CRC:
                begin
                    word0_ok = (crc == b);
                    crc      = 8'hFF;
                    pos      = POS_W1_HI;
                end
                POS_W1_HI:
                begin
                    crc   = crc_step(crc, b);
                    word1 = {b, 8'h00};
                    pos   = POS_W1_LO;
                end
                POS_W1_LO:
                begin
                    crc        = crc_step(crc, b);
                    word1[7:0] = b;
                    pos        = POS_W1_CRC;
                end
                default:
                begin
                    // Last byte of the frame: check both CRCs and decode.
                    pos = POS_W0_HI;
                    if (!(word0_ok && crc == b)) begin
                        crc = 8'hFF;
                        push_error(STATUS_CRC);
                        return;
                    end
                    crc = 8'hFF;
                    r   = '0;
                    r.status = STATUS_OK;
                    if (frame_kind) begin
                        r.serial = {word0, word1};
                    end
                    else begin
                        t_val = -4500 + (17500 * int'(word0)) / 65535;
                        h_val = -600 + (12500 * int'(word1)) / 65535;
                        if (h_val < 0) begin
                            h_val = 0;
                        end
                        if (h_val > 10000) begin
                            h_val = 10000;
                        end
                        r.temp    = t_val[TEMP_W-1:0];
                        r.hum     = h_val[HUM_W-1:0];
                        r.valid   = 1'b1;
                        held_temp = r.temp;
                        held_hum  = r.hum;
                        held_ok   = 1'b1;
                    end
                    expected_readings.push_back(r);
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            errors++;
        endtask

        // Compares one output transfer with the oldest expected reading.
        task check_reading(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            reading_t want;
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected result", 64'(data), '0);
                return;
            end
            want = expected_readings.pop_front();
            if (data[14:0] !== want.temp) begin
                report_mismatch("temperature", 64'(data[14:0]), 64'(want.temp));
            end
            if (data[28:15] !== want.hum) begin
                report_mismatch("humidity", 64'(data[28:15]), 64'(want.hum));
            end
            if (data[60:29] !== want.serial) begin
                report_mismatch("serial number", 64'(data[60:29]), 64'(want.serial));
            end
            if (data[63:61] !== 3'b000) begin
                report_mismatch("data padding", 64'(data[63:61]), '0);
            end
            if (user[1:0] !== want.status) begin
                report_mismatch("status", 64'(user[1:0]), 64'(want.status));
            end
            if (user[2] !== want.valid) begin
                report_mismatch("reading valid", 64'(user[2]), 64'(want.valid));
            end
            if (user[3] !== want.hold) begin
                report_mismatch("from hold", 64'(user[3]), 64'(want.hold));
            end
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic                  cfg_wdata     = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    frame_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  byte_count    = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    logic hold_trigger = 1'b0;
    logic hold_seen    = 1'b0;

    humidity_temp_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_trigger != hold_seen) begin
            hold_seen     <= hold_trigger;
            hold_left     <= LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watch both sides; every transfer goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_reading(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
            end
        end
    end

    // Offers one byte and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b, input logic start, input logic failed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {failed, start};
        @(posedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
        end
        byte_count++;
    endtask

    // Sends the first count bytes of a frame; corrupt bit 0 or 1 spoils the first or
    // second CRC byte.
    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [1:0] corrupt, input int count, input logic start);
        logic [7:0] fb[6];
        fb[0] = w0[15:8];
        fb[1] = w0[7:0];
        fb[2] = frame_scoreboard::crc_step(frame_scoreboard::crc_step(8'hFF, fb[0]), fb[1]);
        fb[3] = w1[15:8];
        fb[4] = w1[7:0];
        fb[5] = frame_scoreboard::crc_step(frame_scoreboard::crc_step(8'hFF, fb[3]), fb[4]);
        if (corrupt[0]) begin
            fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
        end
        if (corrupt[1]) begin
            fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < count; i++) begin
            send_byte(fb[i], (i == 0) ? start : 1'b0, 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 4000));
            default: return 16'($urandom);
        endcase
    endfunction

    // One random group: mostly clean frames, the rest broken frames and noise.
    task automatic send_random_group();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            send_frame(pick_word(), pick_word(), 2'b00, 6, $urandom_range(9) != 0);
        end
        else if (pick < 72) begin
            send_frame(pick_word(), pick_word(), 2'($urandom_range(1, 3)), 6, 1'b1);
        end
        else if (pick < 80) begin
            send_frame(pick_word(), pick_word(), 2'b00, $urandom_range(1, 5), 1'b1);
            send_byte(8'($urandom), 1'($urandom), 1'b1);
        end
        else if (pick < 88) begin
            send_frame(pick_word(), pick_word(), 2'b00, $urandom_range(1, 5), 1'b1);
        end
        else if (pick < 95) begin
            send_byte(8'($urandom), 1'($urandom), 1'b0);
        end
        else begin
            send_byte(8'($urandom), 1'($urandom), 1'b1);
        end
    endtask

    task automatic send_random(input int n);
        int first;
        first = byte_count;
        while (byte_count - first < n) begin
            send_random_group();
        end
    endtask

    // Waits until every reading is out and the pipeline has emptied. The first edge lets the
    // monitor note the last accepted byte before the count is read.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_kind(input logic k);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        sb.set_frame_kind(k);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed measurement frames: errors before any good reading, both word extremes,
        // a failed transfer mid-frame, and a restart in the middle of a frame.
        set_idling(12, 60);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_frame(16'h1234, 16'h5678, 2'b01, 6, 1'b1);
        send_frame(16'h0000, 16'h0000, 2'b00, 6, 1'b1);
        send_frame(16'hABCD, 16'h0000, 2'b00, 2, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_frame(16'h5555, 16'hAAAA, 2'b00, 2, 1'b1);
        send_frame(16'hFFFF, 16'hFFFF, 2'b00, 6, 1'b1);
        send_frame(16'h6666, 16'h9999, 2'b10, 6, 1'b1);

        // Directed serial-number frames.
        write_frame_kind(1'b1);
        send_frame(16'hFFFF, 16'h0001, 2'b00, 6, 1'b1);
        send_frame(16'h8000, 16'h7FFF, 2'b10, 6, 1'b1);

        // Sender idles lightly, receiver heavily.
        write_frame_kind(1'b0);
        send_random(80);
        write_frame_kind(1'b1);
        send_random(50);

        // Roles swapped.
        wait_drained();
        set_idling(60, 12);
        write_frame_kind(1'b0);
        send_random(80);
        write_frame_kind(1'b1);
        send_random(50);

        // No idling; the receiver holds off for a long stretch while transfers keep coming.
        wait_drained();
        set_idling(0, 0);
        write_frame_kind(1'b0);
        hold_trigger <= ~hold_trigger;
        repeat (10) send_byte(8'($urandom), 1'b0, 1'b1);
        repeat (4) send_frame(pick_word(), pick_word(), 2'b00, 6, 1'b1);
        send_random(60);
        write_frame_kind(1'b1);
        send_random(30);
        write_frame_kind(1'b0);
        send_random(30);

        wait_drained();
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/htfd_pkg.sv
sv/htfd_scale.sv
sv/humidity_temp_frame_decoder.sv
tb/humidity_temp_frame_decoder_tb.sv
